// ===== hw/rtl/scth_pkg.sv =====
`timescale 1ns / 1ps

package scth_pkg;

    // Field widths of one transaction.
    localparam int STATE_W  = 10;
    localparam int SYMBOL_W = 8;
    localparam int STATUS_W = 2;

    // Default sizes of the bucket table and of the node pool.
    localparam int BUCKETS_DEF = 64;
    localparam int NODES_DEF   = 256;

    // Hash multipliers and the width of the raw hash.
    // The largest raw hash is 255*31 + 1023*37 = 45756, so 16 bits hold it.
    localparam int HASH_W       = 16;
    localparam int HASH_MUL_SYM = 31;
    localparam int HASH_MUL_ST  = 37;

    // Fixed-point reciprocal used to reduce the hash modulo the bucket count.
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 32;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STATUS_OK   = 2'd0;
    localparam t_status STATUS_MISS = 2'd1;
    localparam t_status STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUOT,
        S_BKT,
        S_HEAD,
        S_WALK
    } t_state;

endpackage

// ===== hw/rtl/state_char_transition_hash_table_unit.sv =====
`timescale 1ns / 1ps

// Channel     | Direction | Handshake            | Payload
// ------------+-----------+----------------------+------------------------------------------
// command     | in        | start high, busy low | i_mode, i_from_state, i_symbol, i_to_state
// result      | out       | o_valid, one cycle   | o_status, o_found_state
//
// An insert passes through hash, quotient, bucket read, and the node and bucket
// write before the result strobe. A lookup passes through hash, quotient and bucket
// read, then walks the chain one node memory read at a time until a match or its end.
// After reset the bucket memory is swept, one entry per cycle, over every bucket
// while busy stays high. The receiver cannot stall: each result shows for one cycle.
module state_char_transition_hash_table_unit #(
    parameter int BUCKETS = scth_pkg::BUCKETS_DEF,
    parameter int NODES   = scth_pkg::NODES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_mode,
    input  logic [scth_pkg::STATE_W-1:0]   i_from_state,
    input  logic [scth_pkg::SYMBOL_W-1:0]  i_symbol,
    input  logic [scth_pkg::STATE_W-1:0]   i_to_state,
    output logic                           o_valid,
    output logic [scth_pkg::STATUS_W-1:0]  o_status,
    output logic [scth_pkg::STATE_W-1:0]   o_found_state
);
    import scth_pkg::*;

    localparam int BW     = $clog2(BUCKETS);
    localparam int NW     = $clog2(NODES);
    localparam int UW     = $clog2(NODES + 1);
    localparam int BKT_DW = NW + 1;
    localparam int NODE_DW = STATE_W + SYMBOL_W + STATE_W + 1 + NW;
    localparam longint unsigned RECIP_L = ((64'd1 << RECIP_SHIFT) / BUCKETS) + 1;
    localparam logic [RECIP_W-1:0]  RECIP      = RECIP_L[RECIP_W-1:0];
    localparam logic [BW-1:0]       LAST_BKT   = BW'(BUCKETS - 1);
    localparam logic [UW-1:0]       POOL_SIZE  = UW'(NODES);
    localparam logic [HASH_W-1:0]   BKT_CONST  = HASH_W'(BUCKETS);

    // Node word layout: key state, key symbol, target, link valid, link.
    localparam int F_LINK  = 0;
    localparam int F_LVAL  = NW;
    localparam int F_TGT   = NW + 1;
    localparam int F_SYM   = F_TGT + STATE_W;
    localparam int F_ST    = F_SYM + SYMBOL_W;

    // Memories: bucket heads with a valid bit, and the node pool.
    logic [BKT_DW-1:0]  bkt_mem  [BUCKETS];
    logic [NODE_DW-1:0] node_mem [NODES];

    t_state r_state, n_state;

    logic                r_mode;
    logic [STATE_W-1:0]  r_st;
    logic [SYMBOL_W-1:0] r_sym;
    logic [STATE_W-1:0]  r_tgt;
    logic [HASH_W-1:0]   r_hash;
    logic [HASH_W-1:0]   r_quot;
    logic [BW-1:0]       r_bucket;
    logic [BW-1:0]       r_clr, n_clr;
    logic [UW-1:0]       r_used, n_used;

    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [STATE_W-1:0]  r_found, n_found;

    logic [BKT_DW-1:0]   r_bkt_rd;
    logic [NODE_DW-1:0]  r_node_rd;

    logic                bkt_we, bkt_re;
    logic [BW-1:0]       bkt_wa, bkt_ra;
    logic [BKT_DW-1:0]   bkt_wd;
    logic                node_we, node_re;
    logic [NW-1:0]       node_wa, node_ra;
    logic [NODE_DW-1:0]  node_wd;

    logic                accept;
    logic [HASH_W-1:0]   hash_in;
    logic [HASH_W+RECIP_W-1:0] quot_prod;
    logic [2*HASH_W-1:0] rem_prod;
    logic [HASH_W-1:0]   rem_full;
    logic                head_valid;
    logic [NW-1:0]       head_node;
    logic                node_match;
    logic                link_valid;
    logic [NW-1:0]       link_node;
    logic                pool_full;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Raw hash of the key; constant multipliers only.
    assign hash_in = HASH_W'(i_symbol) * HASH_W'(HASH_MUL_SYM)
                   + HASH_W'(i_from_state) * HASH_W'(HASH_MUL_ST);

    // Quotient by reciprocal multiply; exact for every hash below 2**16.
    assign quot_prod = (HASH_W+RECIP_W)'(r_hash) * (HASH_W+RECIP_W)'(RECIP);
    assign rem_prod  = (2*HASH_W)'(r_quot) * (2*HASH_W)'(BKT_CONST);
    assign rem_full  = r_hash - rem_prod[HASH_W-1:0];

    assign head_valid = r_bkt_rd[NW];
    assign head_node  = r_bkt_rd[NW-1:0];
    assign node_match = (r_node_rd[F_ST +: STATE_W] == r_st)
                     && (r_node_rd[F_SYM +: SYMBOL_W] == r_sym);
    assign link_valid = r_node_rd[F_LVAL];
    assign link_node  = r_node_rd[F_LINK +: NW];
    assign pool_full  = (r_used == POOL_SIZE);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_BKT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_QUOT;
                end
            end
            S_QUOT: n_state = S_BKT;
            S_BKT:  n_state = S_HEAD;
            S_HEAD: begin
                if (!r_mode && head_valid) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (node_match || !link_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory accesses, pool count and result of each state.
    always_comb begin
        bkt_we   = 1'b0;
        bkt_wa   = r_bucket;
        bkt_wd   = '0;
        bkt_re   = 1'b0;
        bkt_ra   = rem_full[BW-1:0];
        node_we  = 1'b0;
        node_wa  = r_used[NW-1:0];
        node_wd  = {r_st, r_sym, r_tgt, head_valid, head_node};
        node_re  = 1'b0;
        node_ra  = head_node;
        n_clr    = r_clr;
        n_used   = r_used;
        n_valid  = 1'b0;
        n_status = STATUS_OK;
        n_found  = '0;
        case (r_state)
            S_CLEAR: begin
                // Sweep all bucket heads to invalid.
                bkt_we = 1'b1;
                bkt_wa = r_clr;
                n_clr  = r_clr + 1'b1;
            end
            S_BKT: begin
                bkt_re = 1'b1;
            end
            S_HEAD: begin
                if (r_mode) begin
                    n_valid = 1'b1;
                    if (pool_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        // New node goes at the head of its chain.
                        node_we = 1'b1;
                        bkt_we  = 1'b1;
                        bkt_wd  = {1'b1, r_used[NW-1:0]};
                        n_used  = r_used + 1'b1;
                    end
                end else if (head_valid) begin
                    node_re = 1'b1;
                end else begin
                    n_valid  = 1'b1;
                    n_status = STATUS_MISS;
                end
            end
            S_WALK: begin
                if (node_match) begin
                    n_valid = 1'b1;
                    n_found = r_node_rd[F_TGT +: STATE_W];
                end else if (link_valid) begin
                    node_re = 1'b1;
                    node_ra = link_node;
                end else begin
                    n_valid  = 1'b1;
                    n_status = STATUS_MISS;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
    end

    // Transaction payload and hash pipeline registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_st   <= i_from_state;
            r_sym  <= i_symbol;
            r_tgt  <= i_to_state;
            r_hash <= hash_in;
        end
        if (r_state == S_QUOT) begin
            r_quot <= quot_prod[RECIP_SHIFT +: HASH_W];
        end
        if (r_state == S_BKT) begin
            r_bucket <= rem_full[BW-1:0];
        end
        r_status <= n_status;
        r_found  <= n_found;
    end

    // Bucket head memory.
    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        if (bkt_re) begin
            r_bkt_rd <= bkt_mem[bkt_ra];
        end
    end

    // Node pool memory.
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_wa] <= node_wd;
        end
        if (node_re) begin
            r_node_rd <= node_mem[node_ra];
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_state = r_found;

endmodule
